FILE: rtl/core/dcc_enc_pkg.sv
// Shared types and constants of the DCC packet waveform encoder.
package dcc_enc_pkg;

    localparam int TICK_W = 10;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HALF = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HALF  = 1'b1;

    localparam logic [TICK_W-1:0] ZERO_HALF_RESET = 10'd100;
    localparam logic [TICK_W-1:0] ONE_HALF_RESET  = 10'd58;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam logic [13:0] PREAMBLE_ONES = 14'h3FFF;
    localparam int PACKET_BITS = 42;

    typedef struct packed {
        logic level;
        logic busy;
        logic done;
        logic rejected;
    } dcc_enc_res_t;

endpackage

FILE: rtl/core/dcc_enc_wave.sv
// Waveform state and the step of one item: frame build, half timing and repeat count.
module dcc_enc_wave #(
    parameter int FRAME_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                action,
    input  logic [dcc_enc_pkg::BYTE_W-1:0]      loco_address,
    input  logic [dcc_enc_pkg::BYTE_W-1:0]      instruction_byte,
    input  logic [dcc_enc_pkg::BYTE_W-1:0]      repeat_total,
    input  logic [dcc_enc_pkg::TICK_W-1:0]      zero_half_ticks,
    input  logic [dcc_enc_pkg::TICK_W-1:0]      one_half_ticks,
    output dcc_enc_pkg::dcc_enc_res_t           res
);
    import dcc_enc_pkg::*;

    localparam int POS_W = $clog2(FRAME_BITS);

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [BYTE_W-1:0]     reps_reg, reps_next;
    logic                  high_reg, high_next;
    logic [TICK_W-1:0]     count_reg, count_next;
    logic                  sending_reg, sending_next;
    logic                  level_reg, level_next;

    logic [POS_W-1:0]      bit_idx;
    logic                  cur_bit;
    logic [TICK_W-1:0]     half_len;
    logic [TICK_W:0]       count_inc;
    logic [BYTE_W-1:0]     reps_dec;
    logic [BYTE_W-1:0]     check_byte;
    logic                  done;
    logic                  rejected;

    assign bit_idx   = POS_W'(FRAME_BITS - 1) - pos_reg;
    assign cur_bit   = frame_reg[bit_idx];
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign reps_dec  = reps_reg - 1'b1;
    assign check_byte = loco_address ^ instruction_byte;

    always_comb
    begin
        half_len = cur_bit ? one_half_ticks : zero_half_ticks;
        if (half_len == '0)
        begin
            half_len = TICK_W'(1);
        end
    end

    always_comb
    begin
        frame_next   = frame_reg;
        pos_next     = pos_reg;
        reps_next    = reps_reg;
        high_next    = high_reg;
        count_next   = count_reg;
        sending_next = sending_reg;
        level_next   = level_reg;
        done         = 1'b0;
        rejected     = 1'b0;
        if (action == ACT_START)
        begin
            if (sending_reg)
            begin
                rejected = 1'b1;
            end
            else if (repeat_total == '0)
            begin
                done = 1'b1;
            end
            else
            begin
                frame_next   = FRAME_BITS'({PREAMBLE_ONES, 1'b0, loco_address, 1'b0,
                                            instruction_byte, 1'b0, check_byte, 1'b1});
                pos_next     = '0;
                high_next    = 1'b0;
                count_next   = '0;
                reps_next    = repeat_total;
                sending_next = 1'b1;
                level_next   = 1'b0;
            end
        end
        else if (sending_reg)
        begin
            if (count_inc < {1'b0, half_len})
            begin
                count_next = count_inc[TICK_W-1:0];
            end
            else
            begin
                count_next = '0;
                if (!high_reg)
                begin
                    high_next  = 1'b1;
                    level_next = 1'b1;
                end
                else
                begin
                    high_next = 1'b0;
                    if (pos_reg != POS_W'(FRAME_BITS - 1))
                    begin
                        pos_next   = pos_reg + 1'b1;
                        level_next = 1'b0;
                    end
                    else
                    begin
                        pos_next  = '0;
                        reps_next = reps_dec;
                        if (reps_dec == '0)
                        begin
                            sending_next = 1'b0;
                            level_next   = 1'b1;
                            done         = 1'b1;
                        end
                        else
                        begin
                            level_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= '0;
            pos_reg     <= '0;
            reps_reg    <= '0;
            high_reg    <= 1'b0;
            count_reg   <= '0;
            sending_reg <= 1'b0;
            level_reg   <= 1'b0;
        end
        else if (step)
        begin
            frame_reg   <= frame_next;
            pos_reg     <= pos_next;
            reps_reg    <= reps_next;
            high_reg    <= high_next;
            count_reg   <= count_next;
            sending_reg <= sending_next;
            level_reg   <= level_next;
        end
    end

    assign res.level    = level_next;
    assign res.busy     = sending_next;
    assign res.done     = done;
    assign res.rejected = rejected;

endmodule

FILE: rtl/core/dcc_packet_waveform_encoder_unit.sv
// Top level of the DCC packet waveform encoder: input and result registers, configuration.
// Usage: each input transfer is either a tick (action low) or a start of a command
// (action high) carrying address, instruction and repeat count. Every input transfer
// yields exactly one result transfer with the track level, busy, done and rejected flags
// as they stand after that item.
// The input register takes the item at its transfer; when the item advances, the step logic
// writes the waveform state and the result register, from which the result is offered.
// Throughput is one item per cycle while the receiver takes the results; the step logic is
// a single half-counter compare and a frame bit select, so nothing iterates.
// The configuration port writes the half lengths of zero and one bits; writes take effect
// on the next item and must be made while no item is in flight.
// Reset clears both registers' valid flags, idles the encoder with the track low and loads
// the default half lengths of 100 and 58 ticks.
// When the receiver stalls, the result register holds, the input register fills, and
// in_ready falls until the result is taken; no item is lost or repeated.
module dcc_packet_waveform_encoder_unit #(
    parameter int FRAME_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic [7:0]                           loco_address,
    input  logic [7:0]                           instruction_byte,
    input  logic [7:0]                           repeat_total,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 track_level,
    output logic                                 busy_res,
    output logic                                 done_res,
    output logic                                 start_rejected,
    input  logic                                 cfg_we,
    input  logic [dcc_enc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcc_enc_pkg::TICK_W-1:0]       cfg_data
);
    import dcc_enc_pkg::*;

    logic              in_valid_reg;
    logic              action_reg;
    logic [BYTE_W-1:0] addr_reg;
    logic [BYTE_W-1:0] inst_reg;
    logic [BYTE_W-1:0] reps_reg;
    logic              out_valid_reg;
    dcc_enc_res_t      res_reg;
    dcc_enc_res_t      res_next;
    logic [TICK_W-1:0] zero_half_reg;
    logic [TICK_W-1:0] one_half_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            action_reg <= action;
            addr_reg   <= loco_address;
            inst_reg   <= instruction_byte;
            reps_reg   <= repeat_total;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_half_reg <= ZERO_HALF_RESET;
            one_half_reg  <= ONE_HALF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ZERO_HALF: zero_half_reg <= cfg_data;
                CFG_ONE_HALF:  one_half_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    dcc_enc_wave #(
        .FRAME_BITS(FRAME_BITS)
    ) u_wave (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .action           (action_reg),
        .loco_address     (addr_reg),
        .instruction_byte (inst_reg),
        .repeat_total     (reps_reg),
        .zero_half_ticks  (zero_half_reg),
        .one_half_ticks   (one_half_reg),
        .res              (res_next)
    );

    assign out_valid      = out_valid_reg;
    assign track_level    = res_reg.level;
    assign busy_res       = res_reg.busy;
    assign done_res       = res_reg.done;
    assign start_rejected = res_reg.rejected;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.done |-> !res_reg.busy)
        else $error("done reported while still busy");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.rejected |-> res_reg.busy && !res_reg.done)
        else $error("rejected start without a command in progress");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("step taken without a result");

endmodule

FILE: bench/dcc_packet_waveform_encoder_unit_test.sv
// Self-checking testbench for the DCC packet waveform encoder against a cycle-free track model.
module dcc_packet_waveform_encoder_unit_test;
    import dcc_enc_pkg::*;

    localparam int FRAME_LEN = 64;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int HOLD_OFF_AT = 60;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic       action;
        logic [7:0] address;
        logic [7:0] instruction;
        logic [7:0] repeats;
    } dcc_cmd_t;

    typedef struct packed {
        dcc_cmd_t     cmd;
        logic         typed;
        dcc_enc_res_t want;
    } directed_row_t;

    typedef struct packed {
        logic [TICK_W-1:0] zero_half;
        logic [TICK_W-1:0] one_half;
        logic              wide_repeats;
        int                items;
    } phase_t;

    // Result bits in order: level, busy, done, rejected.
    localparam dcc_enc_res_t RES_IDLE_LOW    = 4'b0000;
    localparam dcc_enc_res_t RES_EMPTY_DONE  = 4'b0010;
    localparam dcc_enc_res_t RES_SENDING_LOW = 4'b0100;
    localparam dcc_enc_res_t RES_REJECTED    = 4'b0101;
    localparam dcc_enc_res_t RES_PREDICTED   = 4'b0000;

    directed_row_t directed_rows [0:18] = '{
        {ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b1, RES_IDLE_LOW},
        {ACT_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b1, RES_IDLE_LOW},
        {ACT_START, 8'hFF, 8'h00, 8'h00, 1'b1, RES_EMPTY_DONE},
        {ACT_START, 8'h00, 8'hFF, 8'h01, 1'b1, RES_SENDING_LOW},
        {ACT_START, 8'hFF, 8'hFF, 8'hFF, 1'b1, RES_REJECTED},
        {ACT_START, 8'h00, 8'h00, 8'h00, 1'b1, RES_REJECTED},
        {ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'h55, 8'hAA, 8'h0F, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'hAA, 8'h55, 8'hF0, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'h01, 8'h80, 8'h01, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'h80, 8'h01, 8'h80, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'h3C, 8'hC3, 8'h00, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0, RES_PREDICTED},
        {ACT_START, 8'hA5, 8'h5A, 8'h02, 1'b1, RES_REJECTED},
        {ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'h12, 8'h34, 8'h56, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0, RES_PREDICTED},
        {ACT_TICK,  8'hFF, 8'h00, 8'hFF, 1'b0, RES_PREDICTED}
    };

    phase_t phases [0:4] = '{
        {10'd1,    10'd1,    1'b0, 32'd150},
        {10'd0,    10'd0,    1'b0, 32'd120},
        {10'd2,    10'd1,    1'b0, 32'd80},
        {10'd1023, 10'd1023, 1'b0, 32'd40},
        {10'd1,    10'd3,    1'b1, 32'd90}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [7:0]           loco_address;
    logic [7:0]           instruction_byte;
    logic [7:0]           repeat_total;
    logic                 out_valid;
    logic                 out_ready;
    logic                 track_level;
    logic                 busy_res;
    logic                 done_res;
    logic                 start_rejected;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;

    logic [TICK_W-1:0]    zero_half_len;
    logic [TICK_W-1:0]    one_half_len;
    logic [FRAME_LEN-1:0] frame_shadow;
    int unsigned          bit_pos;
    logic [7:0]           repeats_left;
    logic                 high_half;
    logic [TICK_W-1:0]    half_count;
    logic                 sending;
    logic                 level;

    dcc_enc_res_t awaited_states [$];
    int           errors = 0;
    int           results_seen = 0;
    int           quiet_cycles = 0;
    int           send_run = 0;
    int           recv_run = 0;
    logic         held_off = 1'b0;

    dcc_packet_waveform_encoder_unit #(
        .FRAME_BITS(FRAME_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .loco_address(loco_address),
        .instruction_byte(instruction_byte),
        .repeat_total(repeat_total),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .track_level(track_level),
        .busy_res(busy_res),
        .done_res(done_res),
        .start_rejected(start_rejected),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic dcc_enc_res_t predict_track_state(input dcc_cmd_t cmd);
        dcc_enc_res_t r;
        int unsigned  len;
        int unsigned  next;
        logic [7:0]   check;
        r = '0;
        if (cmd.action == ACT_START)
        begin
            if (sending)
            begin
                r.rejected = 1'b1;
            end
            else if (cmd.repeats == 8'd0)
            begin
                r.done = 1'b1;
            end
            else
            begin
                check = cmd.address ^ cmd.instruction;
                frame_shadow = {{(FRAME_LEN - PACKET_BITS){1'b0}}, PREAMBLE_ONES,
                                1'b0, cmd.address, 1'b0, cmd.instruction, 1'b0, check, 1'b1};
                bit_pos = 0;
                high_half = 1'b0;
                half_count = '0;
                repeats_left = cmd.repeats;
                sending = 1'b1;
                level = 1'b0;
            end
        end
        else if (sending)
        begin
            len = 32'(frame_shadow[FRAME_LEN - 1 - bit_pos] ? one_half_len : zero_half_len);
            if (len == 0)
            begin
                len = 1;
            end
            next = half_count + 1;
            if (next < len)
            begin
                half_count = next[TICK_W-1:0];
            end
            else
            begin
                half_count = '0;
                if (!high_half)
                begin
                    high_half = 1'b1;
                    level = 1'b1;
                end
                else
                begin
                    high_half = 1'b0;
                    if (bit_pos + 1 < FRAME_LEN)
                    begin
                        bit_pos = bit_pos + 1;
                        level = 1'b0;
                    end
                    else
                    begin
                        bit_pos = 0;
                        repeats_left = repeats_left - 8'd1;
                        if (repeats_left == 8'd0)
                        begin
                            sending = 1'b0;
                            level = 1'b1;
                            r.done = 1'b1;
                        end
                        else
                        begin
                            level = 1'b0;
                        end
                    end
                end
            end
        end
        r.level = level;
        r.busy = sending;
        return r;
    endfunction

    function automatic int draw_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left = run_left - 1;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Starts and ticks alike while idle and mostly ticks while sending, so that whole frames get through.
    function automatic dcc_cmd_t random_cmd(input logic wide);
        dcc_cmd_t c;
        int       pick;
        c.address = 8'($urandom_range(0, 255));
        c.instruction = 8'($urandom_range(0, 255));
        if (sending)
        begin
            c.action = ($urandom_range(0, 29) == 0) ? ACT_START : ACT_TICK;
        end
        else
        begin
            c.action = ($urandom_range(0, 1) == 0) ? ACT_START : ACT_TICK;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            c.repeats = 8'd0;
        end
        else if (pick < 78)
        begin
            c.repeats = 8'd1;
        end
        else if (pick < 92)
        begin
            c.repeats = 8'd2;
        end
        else if (wide)
        begin
            c.repeats = 8'($urandom_range(0, 255));
        end
        else
        begin
            c.repeats = 8'($urandom_range(3, 4));
        end
        return c;
    endfunction

    task automatic offer_cmd(input dcc_cmd_t cmd, input logic typed, input dcc_enc_res_t want);
        int gap;
        dcc_enc_res_t predicted;
        gap = draw_gap(send_run);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= cmd.action;
        loco_address <= cmd.address;
        instruction_byte <= cmd.instruction;
        repeat_total <= cmd.repeats;
        do @(posedge clk); while (!in_ready);
        predicted = predict_track_state(cmd);
        awaited_states.push_back(typed ? want : predicted);
    endtask

    task automatic settle_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_states.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_half_lengths(input logic [TICK_W-1:0] zero_len,
                                    input logic [TICK_W-1:0] one_len);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ZERO_HALF;
        cfg_data <= zero_len;
        @(negedge clk);
        cfg_index <= CFG_ONE_HALF;
        cfg_data <= one_len;
        @(negedge clk);
        cfg_we <= 1'b0;
        zero_half_len = zero_len;
        one_half_len = one_len;
    endtask

    task automatic report_field(input string name, input logic want_bit, input logic got_bit);
        if (want_bit !== got_bit)
        begin
            $display("%0t: %s expected %b, got %b", $time, name, want_bit, got_bit);
            errors++;
        end
    endtask

    initial
    begin : result_sink
        int           gap;
        dcc_enc_res_t got;
        dcc_enc_res_t want;
        out_ready = 1'b0;
        forever
        begin
            gap = draw_gap(recv_run);
            if (!held_off && results_seen == HOLD_OFF_AT)
            begin
                gap = HOLD_OFF_CYCLES;
                held_off = 1'b1;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = {track_level, busy_res, done_res, start_rejected};
            results_seen++;
            if (awaited_states.size() == 0)
            begin
                $display("%0t: result transfer with nothing awaited, got %b", $time, got);
                errors++;
            end
            else
            begin
                want = awaited_states.pop_front();
                report_field("track_level", want.level, got.level);
                report_field("busy_res", want.busy, got.busy);
                report_field("done_res", want.done, got.done);
                report_field("start_rejected", want.rejected, got.rejected);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("dcc_packet_waveform_encoder_unit_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_TICK;
        loco_address = 8'd0;
        instruction_byte = 8'd0;
        repeat_total = 8'd0;
        cfg_we = 1'b0;
        cfg_index = CFG_ZERO_HALF;
        cfg_data = '0;
        zero_half_len = ZERO_HALF_RESET;
        one_half_len = ONE_HALF_RESET;
        frame_shadow = '0;
        bit_pos = 0;
        repeats_left = 8'd0;
        high_half = 1'b0;
        half_count = '0;
        sending = 1'b0;
        level = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[i])
        begin
            offer_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        end
        foreach (phases[p])
        begin
            settle_pipeline();
            set_half_lengths(phases[p].zero_half, phases[p].one_half);
            repeat (phases[p].items)
            begin
                offer_cmd(random_cmd(phases[p].wide_repeats), 1'b0, RES_PREDICTED);
            end
        end
        settle_pipeline();
        if (errors == 0)
        begin
            $display("dcc_packet_waveform_encoder_unit_test OK");
        end
        else
        begin
            $display("dcc_packet_waveform_encoder_unit_test NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/dcc_enc_pkg.sv
rtl/core/dcc_enc_wave.sv
rtl/core/dcc_packet_waveform_encoder_unit.sv
bench/dcc_packet_waveform_encoder_unit_test.sv
